// ===== hdl/dorf_pkg.sv =====
// Package for the drop-oldest ring FIFO: request/response payload structs
// and operation codes. No dependencies.
`timescale 1ns / 1ps

package dorf_pkg;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam int CAP_LOG2_W     = 4;
  localparam int OCC_W          = 11;
  localparam logic [3:0] CAP_LOG2_RESET = 4'd10;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] push_data;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [31:0]      read_data;
    logic             dropped_now;
    logic [OCC_W-1:0] occupancy;
    logic [31:0]      push_total;
    logic [31:0]      drop_total;
  } rsp_t;

endpackage

// ===== hdl/drop_oldest_ring_fifo.sv =====
// Drop-oldest ring FIFO top level: counters, slot memory, response pipeline.
// Depends on dorf_pkg (payload structs, operation codes).
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid/req_ready/req): one operation per request,
//   push (write push_data, discarding the oldest entry when full), pop
//   (remove and return the oldest entry) or peek (return the newest entry).
//   Response channel (rsp_valid/rsp_ready/rsp): exactly one response per
//   request, in order, with status, read data, drop flag, occupancy and the
//   wrapping push and drop totals.
//   cfg_we/cfg_wdata: writes capacity_log2 (clamped to 1..log2 STORE_DEPTH)
//   and empties the ring; totals are kept. Write only while idle.
// Timing
//   A request passes through the read stage (slot memory read, registered)
//   and then the response register. Counters and the memory write are
//   updated in the accept cycle, so back-to-back requests see each other's
//   effects; one request per cycle is sustained while rsp_ready stays high.
// Reset and stalls
//   Synchronous active-high rst empties the ring, zeroes the totals and
//   sets capacity_log2 to 10. Slot contents are not cleared; only written
//   slots are ever read. When rsp_ready is low the response register and the
//   read stage fill and req_ready drops; nothing is lost.
module drop_oldest_ring_fifo #(
  parameter int STORE_DEPTH = 1024,
  parameter int ELEM_WIDTH  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  dorf_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output dorf_pkg::rsp_t                    rsp,
  input  logic                              cfg_we,
  input  logic [dorf_pkg::CAP_LOG2_W-1:0]   cfg_wdata
);

  // floor(log2(STORE_DEPTH)): largest usable capacity exponent
  localparam int MAXLG = $clog2(STORE_DEPTH + 1) - 1;
  localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  // counters wrap mod 2*max capacity, enough to tell full from empty
  localparam int CW    = MAXLG + 1;

  // Slot memory
  logic [ELEM_WIDTH-1:0] mem [STORE_DEPTH];
  logic [ELEM_WIDTH-1:0] mem_q;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  // Control state
  logic [dorf_pkg::CAP_LOG2_W-1:0] cap_lg;
  logic [CW-1:0] write_count;
  logic [CW-1:0] read_count;
  logic [31:0]   pushes_seen;
  logic [31:0]   drops_seen;

  logic [CW-1:0] write_count_next;
  logic [CW-1:0] read_count_next;
  logic [31:0]   pushes_seen_next;
  logic [31:0]   drops_seen_next;

  // Read stage
  logic           s1_valid;
  logic           s1_rd;     // response carries memory data
  dorf_pkg::rsp_t s1_rsp;
  dorf_pkg::rsp_t s1_rsp_next;
  logic           s1_move;
  dorf_pkg::rsp_t rsp_next;

  logic          accept;
  logic [4:0]    lg_eff;
  logic [CW-1:0] cap_val;
  logic [CW-1:0] cap_mask;
  logic [CW-1:0] occ;
  logic [CW-1:0] occ_next;
  logic          full;
  logic          empty;

  // Effective capacity: 0 acts as 1, above the store acts as the store
  always_comb begin
    lg_eff = {1'b0, cap_lg};
    if (cap_lg == 4'd0) begin
      lg_eff = 5'd1;
    end else if ({1'b0, cap_lg} > 5'(MAXLG)) begin
      lg_eff = 5'(MAXLG);
    end
  end

  assign cap_val  = CW'(1) << lg_eff;
  assign cap_mask = cap_val - CW'(1);
  assign occ      = write_count - read_count;
  assign full     = (occ >= cap_val);
  assign empty    = (occ == '0);

  // Handshakes: the read stage drains into the response register
  assign s1_move   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_move;
  assign accept    = req_valid && req_ready;

  // Request decode, counter updates, memory access
  always_comb begin
    write_count_next = write_count;
    read_count_next  = read_count;
    pushes_seen_next = pushes_seen;
    drops_seen_next  = drops_seen;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    wr_addr          = AW'(write_count & cap_mask);
    rd_addr          = AW'(read_count & cap_mask);
    s1_rsp_next      = '0;
    case (req.operation)
      dorf_pkg::OP_PUSH: begin
        wr_en            = accept;
        write_count_next = write_count + CW'(1);
        pushes_seen_next = pushes_seen + 32'd1;
        s1_rsp_next.ok   = 1'b1;
        if (full) begin
          read_count_next         = read_count + CW'(1);
          drops_seen_next         = drops_seen + 32'd1;
          s1_rsp_next.dropped_now = 1'b1;
        end
      end
      dorf_pkg::OP_POP: begin
        if (!empty) begin
          rd_en           = accept;
          read_count_next = read_count + CW'(1);
          s1_rsp_next.ok  = 1'b1;
        end
      end
      dorf_pkg::OP_PEEK: begin
        if (!empty) begin
          rd_en          = accept;
          rd_addr        = AW'((write_count - CW'(1)) & cap_mask);
          s1_rsp_next.ok = 1'b1;
        end
      end
      default: begin
        // unused code: no operation, reports current counts
      end
    endcase
    occ_next               = write_count_next - read_count_next;
    s1_rsp_next.occupancy  = dorf_pkg::OCC_W'(occ_next);
    s1_rsp_next.push_total = pushes_seen_next;
    s1_rsp_next.drop_total = drops_seen_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= ELEM_WIDTH'(req.push_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Counters and capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_lg      <= dorf_pkg::CAP_LOG2_RESET;
      write_count <= '0;
      read_count  <= '0;
      pushes_seen <= '0;
      drops_seen  <= '0;
    end else if (cfg_we) begin
      // capacity change flushes the ring, totals stay
      cap_lg      <= cfg_wdata;
      write_count <= '0;
      read_count  <= '0;
    end else if (accept) begin
      write_count <= write_count_next;
      read_count  <= read_count_next;
      pushes_seen <= pushes_seen_next;
      drops_seen  <= drops_seen_next;
    end
  end

  // Read stage: holds the request beside the registered memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rsp <= s1_rsp_next;
      s1_rd  <= rd_en;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // memory data joins the response on its way out
  always_comb begin
    rsp_next           = s1_rsp;
    rsp_next.read_data = s1_rd ? 32'(mem_q) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp <= rsp_next;
    end
  end

  // Checks
  a_occ_bounded: assert property (@(posedge clk) disable iff (rst)
    occ <= cap_val)
    else $error("occupancy above capacity in use");

  a_drop_is_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.dropped_now || rsp.ok))
    else $error("drop reported on a failed request");

  a_empty_read_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_we && empty && (req.operation != dorf_pkg::OP_PUSH))
      |=> ($stable(write_count) && $stable(read_count)))
    else $error("read on empty ring moved the counters");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_we && (req.operation == dorf_pkg::OP_PUSH))
      |=> (pushes_seen == $past(pushes_seen) + 32'd1))
    else $error("push total not advanced");

endmodule

// ===== dv/drop_oldest_ring_fifo_tb.sv =====
// Self-checking testbench for drop_oldest_ring_fifo: directed and random
// requests across capacity settings, checked against an in-bench ring model.
// Depends on dorf_pkg (req_t, rsp_t, operation codes) and the top level.
`timescale 1ns / 1ps

module drop_oldest_ring_fifo_tb;

  // Unused operation code; the block must answer it as a no-op.
  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam int         STORE_DEPTH = 1024;
  localparam int         IDX_W       = $clog2(STORE_DEPTH);
  localparam int         MAX_LOG2    = 10;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         REPORT_MAX  = 10;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  dorf_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_ready;
  dorf_pkg::rsp_t rsp;
  logic           cfg_we;
  logic [3:0]     cfg_wdata;

  drop_oldest_ring_fifo dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Ring model: own copy of the slot store, the free-running write/read
  // counts, the wrapping totals and the capacity register.
  // ---------------------------------------------------------------------
  bit [31:0] ring_slot [STORE_DEPTH];
  bit [31:0] wr_count;
  bit [31:0] rd_count;
  bit [31:0] push_count;
  bit [31:0] drop_count;
  bit [3:0]  cap_log2;

  // Responses still owed by the block, oldest first.
  dorf_pkg::rsp_t fifo_rsp_due [$];

  // Run bookkeeping.
  int  fail_count;
  int  rsp_count;
  int  req_count;
  int  empty_reads;
  int  cfg_writes;
  int  cycle_count;
  int  peak_occupancy;
  bit  idling_on;

  // Register value 0 acts as 1, anything above log2(depth) as log2(depth).
  function automatic int unsigned ring_size();
    int unsigned lg;
    lg = cap_log2;
    if (lg < 1) lg = 1;
    if (lg > MAX_LOG2) lg = MAX_LOG2;
    return 1 << lg;
  endfunction

  // Applies one request to the ring model and returns the response it owes.
  function automatic dorf_pkg::rsp_t next_fifo_response(dorf_pkg::req_t r);
    dorf_pkg::rsp_t res;
    bit [31:0]      occ;
    int unsigned    mask;
    mask = ring_size() - 1;
    occ  = wr_count - rd_count;
    res  = '0;
    case (r.operation)
      dorf_pkg::OP_PUSH: begin
        if (occ >= ring_size()) begin
          // full: oldest entry goes first
          rd_count++;
          drop_count++;
          res.dropped_now = 1'b1;
        end
        ring_slot[IDX_W'(wr_count & mask)] = r.push_data;
        wr_count++;
        push_count++;
        res.ok = 1'b1;
      end
      dorf_pkg::OP_POP: begin
        if (occ != 0) begin
          res.read_data = ring_slot[IDX_W'(rd_count & mask)];
          rd_count++;
          res.ok = 1'b1;
        end else begin
          empty_reads++;
        end
      end
      dorf_pkg::OP_PEEK: begin
        if (occ != 0) begin
          res.read_data = ring_slot[IDX_W'((wr_count - 1) & mask)];
          res.ok = 1'b1;
        end else begin
          empty_reads++;
        end
      end
      default: ;
    endcase
    occ = wr_count - rd_count;
    if (occ > peak_occupancy) peak_occupancy = occ;
    res.occupancy  = occ[dorf_pkg::OCC_W-1:0];
    res.push_total = push_count;
    res.drop_total = drop_count;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Request side. valid is never dropped in the step where the previous
  // request was taken unless an idle gap follows, so a back-to-back
  // request keeps valid high with a single assignment.
  // ---------------------------------------------------------------------
  task automatic send_request(input logic [1:0] op, input logic [31:0] data);
    dorf_pkg::req_t r;
    r.operation = op;
    r.push_data = data;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    fifo_rsp_due.push_back(next_fifo_response(r));
    req_count++;
  endtask

  // Sender holds off until every owed response has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (fifo_rsp_due.size() != 0) @(posedge clk);
  endtask

  // Capacity write, only with the block idle; flushes the ring, keeps totals.
  task automatic write_capacity(input logic [3:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap_log2 = value;
    wr_count = '0;
    rd_count = '0;
    cfg_writes++;
  endtask

  function automatic logic [31:0] rand_element();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // push_pct of requests are pushes; the rest mostly pops, then peeks,
  // with a few unused codes.
  function automatic logic [1:0] rand_operation(input int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return dorf_pkg::OP_PUSH;
    roll = $urandom_range(0, 99);
    if (roll < 55) return dorf_pkg::OP_POP;
    if (roll < 90) return dorf_pkg::OP_PEEK;
    return OP_NONE;
  endfunction

  // ---------------------------------------------------------------------
  // Response side: random rsp_ready stall bursts while idling is on.
  // ---------------------------------------------------------------------
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready  <= 1'b1;
      stall_left = 0;
    end else if (stall_left != 0) begin
      rsp_ready <= 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      rsp_ready  <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Each accepted response is matched against the oldest owed one.
  always @(posedge clk) begin
    dorf_pkg::rsp_t want;
    string          diff;
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_count++;
      if (fifo_rsp_due.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("[%0t] response with none owed: ok=%0d data=%h occ=%0d",
                   $realtime, rsp.ok, rsp.read_data, rsp.occupancy);
        fail_count++;
      end else begin
        want = fifo_rsp_due.pop_front();
        diff = "";
        if (rsp.ok          !== want.ok)          diff = {diff, " ok"};
        if (rsp.read_data   !== want.read_data)   diff = {diff, " read_data"};
        if (rsp.dropped_now !== want.dropped_now) diff = {diff, " dropped_now"};
        if (rsp.occupancy   !== want.occupancy)   diff = {diff, " occupancy"};
        if (rsp.push_total  !== want.push_total)  diff = {diff, " push_total"};
        if (rsp.drop_total  !== want.drop_total)  diff = {diff, " drop_total"};
        if (diff != "") begin
          if (fail_count < REPORT_MAX) begin
            $display("[%0t] response %0d mismatch on%s", $realtime, rsp_count, diff);
            $display("  expected ok=%0d data=%h drop=%0d occ=%0d pushes=%0d drops=%0d",
                     want.ok, want.read_data, want.dropped_now, want.occupancy,
                     want.push_total, want.drop_total);
            $display("  actual   ok=%0d data=%h drop=%0d occ=%0d pushes=%0d drops=%0d",
                     rsp.ok, rsp.read_data, rsp.dropped_now, rsp.occupancy,
                     rsp.push_total, rsp.drop_total);
          end
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d responses owed",
               cycle_count, fifo_rsp_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Fresh out of reset: empty pop and peek, unused code, at capacity 1024.
  task automatic test_reset_state();
    send_request(dorf_pkg::OP_POP,  32'h0000_0000);
    send_request(dorf_pkg::OP_PEEK, 32'h0000_0000);
    send_request(OP_NONE,           32'hFFFF_FFFF);
  endtask

  // Data extremes through push, peek and pop, ending on an empty pop.
  task automatic test_data_extremes();
    send_request(dorf_pkg::OP_PUSH, 32'h0000_0000);
    send_request(dorf_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_request(dorf_pkg::OP_PEEK, 32'h1234_5678);
    send_request(dorf_pkg::OP_POP,  32'h0000_0000);
    send_request(dorf_pkg::OP_POP,  32'h0000_0000);
    send_request(dorf_pkg::OP_POP,  32'hFFFF_FFFF);
  endtask

  // Register value 0 acts as a 2-entry ring; third push drops the oldest.
  task automatic test_smallest_ring();
    write_capacity(4'd0);
    send_request(dorf_pkg::OP_PUSH, 32'hA5A5_0001);
    send_request(dorf_pkg::OP_PUSH, 32'h5A5A_0002);
    send_request(dorf_pkg::OP_PUSH, 32'hC3C3_0003);
    send_request(dorf_pkg::OP_PEEK, 32'h0000_0000);
    send_request(dorf_pkg::OP_POP,  32'h0000_0000);
    send_request(dorf_pkg::OP_POP,  32'h0000_0000);
    send_request(dorf_pkg::OP_POP,  32'h0000_0000);
    send_request(dorf_pkg::OP_PUSH, 32'h8000_0001);
    send_request(OP_NONE,           32'h0000_0000);
  endtask

  // A capacity write empties the ring but keeps the totals; 12 clamps to 10.
  task automatic test_flush_on_write();
    write_capacity(4'd12);
    send_request(dorf_pkg::OP_PUSH, 32'hDEAD_BEEF);
    send_request(dorf_pkg::OP_PUSH, 32'h0BAD_F00D);
    write_capacity(4'd1);
    send_request(dorf_pkg::OP_POP,  32'h0000_0000);
    send_request(dorf_pkg::OP_PEEK, 32'h0000_0000);
    send_request(dorf_pkg::OP_PUSH, 32'h7FFF_FFFF);
    send_request(dorf_pkg::OP_POP,  32'h0000_0000);
  endtask

  // Largest ring (11 clamps to 10): fill past 1024 so it overwrites, then mix.
  task automatic test_full_depth();
    write_capacity(4'd11);
    for (int i = 0; i < STORE_DEPTH + 8; i++)
      send_request(dorf_pkg::OP_PUSH, rand_element());
    for (int i = 0; i < 40; i++)
      send_request(rand_operation(40), rand_element());
  endtask

  // Random phases over a spread of capacities; the last one runs without
  // idling so the block sees a sustained stream.
  task automatic test_random_phases();
    logic [3:0] caps [10];
    int         pct  [3];
    int         push_pct;
    caps = '{4'd1, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd4, 4'd14, 4'd6, 4'd10};
    pct  = '{30, 50, 70};
    for (int ph = 0; ph < 10; ph++) begin
      write_capacity(caps[ph]);
      idling_on = (ph == 9) ? 1'b0 : (ph % 3 != 2);
      push_pct  = pct[$urandom_range(0, 2)];
      for (int i = 0; i < 15; i++) begin
        // occasional full hold-off so the pipeline drains mid-phase
        if (ph != 9 && $urandom_range(0, 59) == 0)
          wait_drained();
        send_request(rand_operation(push_pct), rand_element());
      end
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    idling_on   = 1'b1;
    wr_count    = '0;
    rd_count    = '0;
    push_count  = '0;
    drop_count  = '0;
    cap_log2    = dorf_pkg::CAP_LOG2_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_data_extremes();
    test_smallest_ring();
    test_flush_on_write();
    test_full_depth();
    test_random_phases();

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Ran %0d requests (%0d pushes, %0d drops, %0d empty reads)",
             req_count, push_count, drop_count, empty_reads);
    $display("over %0d capacity writes; checked %0d responses, peak occupancy %0d, %0d failures",
             cfg_writes, rsp_count, peak_occupancy, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dorf_pkg.sv
hdl/drop_oldest_ring_fifo.sv
dv/drop_oldest_ring_fifo_tb.sv
